### hw/rtl/windowed_min_max_mean_two_channel_defines.svh
// Assertion macros for the windowed statistics block.
`ifndef WINDOWED_MIN_MAX_MEAN_TWO_CHANNEL_DEFINES_SVH
`define WINDOWED_MIN_MAX_MEAN_TWO_CHANNEL_DEFINES_SVH
`ifndef SYNTHESIS
`define WMM_ASSERT_HOLDS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("wmm check failed");
`define WMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wmm check failed");
`else
`define WMM_ASSERT_HOLDS(lbl, expr)
`define WMM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/wmm_pkg.sv
// Shared types and constants for the windowed statistics block.
`default_nettype none
package wmm_pkg;
  localparam int COUNT_BITS    = 8;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_WORD_LSB  = 2;

  // word index of each config register
  localparam logic [CFG_ADDR_BITS-CFG_WORD_LSB-1:0] REG_WINDOW_LENGTH = 1'b0;

  localparam logic [COUNT_BITS-1:0] WINDOW_LENGTH_RESET = 8'd31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start_add;
    logic start_close;
    logic add_en;
    logic samp_en;
    logic add_last;
    logic div_en;
  } chan_ctl_t;
endpackage
`default_nettype wire

### hw/rtl/wmm_chan.sv
// One channel: bit-serial adder and compares, serial divider, latched stats.
`default_nettype none
module wmm_chan #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire wmm_pkg::chan_ctl_t              ctl,
  input  wire logic [SAMPLE_BITS-1:0]          sample,
  input  wire logic [wmm_pkg::COUNT_BITS-1:0]  divisor,
  output logic      [SAMPLE_BITS-1:0]          win_max,
  output logic      [SAMPLE_BITS-1:0]          win_min,
  output logic      [SAMPLE_BITS-1:0]          win_mean
);
  localparam int CB       = wmm_pkg::COUNT_BITS;
  localparam int SUM_BITS = SAMPLE_BITS + CB;

  logic [SAMPLE_BITS-1:0] samp_r, samp_nxt;
  logic [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic                   carry_r, carry_nxt;
  logic                   gt_r, gt_nxt;
  logic                   lt_r, lt_nxt;
  logic [SAMPLE_BITS-1:0] win_max_r, win_max_nxt;
  logic [SAMPLE_BITS-1:0] win_min_r, win_min_nxt;
  logic [CB-1:0]          rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0] quo_r, quo_nxt;

  logic          samp_bit;
  logic          sum_bit;
  logic          carry_out;
  logic [CB:0]   trial;
  logic [CB:0]   trial_diff;
  logic          trial_ge;

  assign samp_bit   = ctl.samp_en ? samp_r[0] : 1'b0;
  assign sum_bit    = sum_r[0] ^ samp_bit ^ carry_r;
  assign carry_out  = (sum_r[0] & samp_bit) | (sum_r[0] & carry_r) | (samp_bit & carry_r);
  // restoring division, one quotient bit per cycle
  assign trial      = {rem_r, quo_r[SAMPLE_BITS-1]};
  assign trial_ge   = trial >= {1'b0, divisor};
  assign trial_diff = trial - {1'b0, divisor};

  always_comb begin
    samp_nxt    = samp_r;
    max_nxt     = max_r;
    min_nxt     = min_r;
    sum_nxt     = sum_r;
    carry_nxt   = carry_r;
    gt_nxt      = gt_r;
    lt_nxt      = lt_r;
    win_max_nxt = win_max_r;
    win_min_nxt = win_min_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    if (ctl.start_close) begin
      // close the window: latch, then the new window holds only this sample
      win_max_nxt = max_r;
      win_min_nxt = min_r;
      rem_nxt     = sum_r[SUM_BITS-1:SAMPLE_BITS];
      quo_nxt     = sum_r[SAMPLE_BITS-1:0];
      max_nxt     = sample;
      min_nxt     = sample;
      sum_nxt     = SUM_BITS'(sample);
    end
    if (ctl.start_add) begin
      samp_nxt  = sample;
      carry_nxt = 1'b0;
      gt_nxt    = 1'b0;
      lt_nxt    = 1'b0;
    end
    if (ctl.add_en) begin
      sum_nxt   = {sum_bit, sum_r[SUM_BITS-1:1]};
      carry_nxt = carry_out;
      if (ctl.samp_en) begin
        samp_nxt = {samp_r[0], samp_r[SAMPLE_BITS-1:1]};
        max_nxt  = {max_r[0], max_r[SAMPLE_BITS-1:1]};
        min_nxt  = {min_r[0], min_r[SAMPLE_BITS-1:1]};
        // LSB first: the highest differing bit decides last
        if (samp_r[0] != max_r[0]) begin
          gt_nxt = samp_r[0];
        end
        if (samp_r[0] != min_r[0]) begin
          lt_nxt = min_r[0];
        end
      end
      if (ctl.add_last) begin
        if (gt_r) begin
          max_nxt = samp_r;
        end
        if (lt_r) begin
          min_nxt = samp_r;
        end
      end
    end
    if (ctl.div_en) begin
      rem_nxt = trial_ge ? trial_diff[CB-1:0] : trial[CB-1:0];
      quo_nxt = {quo_r[SAMPLE_BITS-2:0], trial_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r     <= '0;
      min_r     <= '1;
      sum_r     <= '0;
      win_max_r <= '0;
      win_min_r <= '0;
      quo_r     <= '0;
    end else begin
      max_r     <= max_nxt;
      min_r     <= min_nxt;
      sum_r     <= sum_nxt;
      win_max_r <= win_max_nxt;
      win_min_r <= win_min_nxt;
      quo_r     <= quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samp_r  <= samp_nxt;
    carry_r <= carry_nxt;
    gt_r    <= gt_nxt;
    lt_r    <= lt_nxt;
    rem_r   <= rem_nxt;
  end

  // quotient register holds the latched mean between windows
  assign win_max  = win_max_r;
  assign win_min  = win_min_r;
  assign win_mean = quo_r;
endmodule
`default_nettype wire

### hw/rtl/wmm_ctrl.sv
// Sequencer: window count, bit step counter and channel control.
`default_nettype none
module wmm_ctrl #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic                            active,
  input  wire logic [wmm_pkg::COUNT_BITS-1:0]  wlen,
  input  wire logic                            out_free,
  output wmm_pkg::chan_ctl_t                   ctl,
  output logic      [wmm_pkg::COUNT_BITS-1:0]  divisor,
  output logic                                 done,
  output logic                                 out_load,
  output logic                                 idle
);
  localparam int CB        = wmm_pkg::COUNT_BITS;
  localparam int SUM_BITS  = SAMPLE_BITS + CB;
  localparam int STEP_BITS = $clog2(SUM_BITS);
  localparam logic [STEP_BITS-1:0] ADD_LAST = STEP_BITS'(SUM_BITS - 1);
  localparam logic [STEP_BITS-1:0] DIV_LAST = STEP_BITS'(SAMPLE_BITS - 1);
  localparam logic [STEP_BITS-1:0] SAMP_END = STEP_BITS'(SAMPLE_BITS);

  wmm_pkg::state_t state_r, state_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;
  logic [CB-1:0]        cnt_r, cnt_nxt;
  logic [CB-1:0]        div_r, div_nxt;
  logic                 done_r, done_nxt;
  logic [CB-1:0]        len_eff;
  logic                 close;

  assign len_eff = (wlen == '0) ? CB'(1) : wlen;
  assign close   = active && (cnt_r >= len_eff);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wmm_pkg::ST_IDLE: begin
        if (start) begin
          if (!active) begin
            state_nxt = wmm_pkg::ST_OUT;
          end else if (close) begin
            state_nxt = wmm_pkg::ST_DIV;
          end else begin
            state_nxt = wmm_pkg::ST_ADD;
          end
        end
      end
      wmm_pkg::ST_ADD: begin
        if (step_r == ADD_LAST) begin
          state_nxt = wmm_pkg::ST_OUT;
        end
      end
      wmm_pkg::ST_DIV: begin
        if (step_r == DIV_LAST) begin
          state_nxt = wmm_pkg::ST_OUT;
        end
      end
      wmm_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = wmm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wmm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    out_load = 1'b0;
    unique case (state_r)
      wmm_pkg::ST_IDLE: begin
        ctl.start_add   = start && active && !close;
        ctl.start_close = start && close;
      end
      wmm_pkg::ST_ADD: begin
        ctl.add_en   = 1'b1;
        ctl.samp_en  = step_r < SAMP_END;
        ctl.add_last = step_r == ADD_LAST;
      end
      wmm_pkg::ST_DIV: begin
        ctl.div_en = 1'b1;
      end
      wmm_pkg::ST_OUT: begin
        out_load = out_free;
      end
      default: ctl = '0;
    endcase
  end

  always_comb begin
    step_nxt = '0;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    done_nxt = done_r;
    if (state_r == wmm_pkg::ST_ADD || state_r == wmm_pkg::ST_DIV) begin
      step_nxt = step_r + STEP_BITS'(1);
    end
    if (ctl.start_close) begin
      div_nxt = cnt_r;
      cnt_nxt = CB'(1);
    end else if (ctl.start_add) begin
      cnt_nxt = cnt_r + CB'(1);
    end
    if (start && idle) begin
      done_nxt = close;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wmm_pkg::ST_IDLE;
      step_r  <= '0;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
  end

  assign idle    = state_r == wmm_pkg::ST_IDLE;
  assign divisor = div_r;
  assign done    = done_r;
endmodule
`default_nettype wire

### hw/rtl/windowed_min_max_mean_two_channel.sv
// A beat with active low goes straight to the output state; one that closes a window runs the
// serial divider; any other active beat runs the bit-serial adder across the full sum width.
// One beat is in work at a time; the next is taken once the result enters the output register.
// Synchronous active-low reset clears running max/sum, sets running min to all ones,
// zeroes the latched statistics and sample count, and sets window_length to 31.
`default_nettype none
`include "windowed_min_max_mean_two_channel_defines.svh"
module windowed_min_max_mean_two_channel #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // light_sample, soil_sample (from bit 0: soil, then light)
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,
  // active
  input  wire logic                                  in_tuser,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // from bit 0: soil max, soil min, soil mean, light max, light min, light mean
  output logic      [((6*SAMPLE_BITS+7)/8)*8-1:0]    out_tdata,
  // window_done
  output logic                                       out_tuser,
  input  wire logic                                  cfg_psel,
  input  wire logic                                  cfg_penable,
  input  wire logic                                  cfg_pwrite,
  input  wire logic [wmm_pkg::CFG_ADDR_BITS-1:0]     cfg_paddr,
  input  wire logic [wmm_pkg::CFG_DATA_BITS-1:0]     cfg_pwdata,
  output logic      [wmm_pkg::CFG_DATA_BITS-1:0]     cfg_prdata,
  output logic                                       cfg_pready
);
  localparam int SB         = SAMPLE_BITS;
  localparam int CB         = wmm_pkg::COUNT_BITS;
  localparam int OUT_DATA_W = ((6*SAMPLE_BITS+7)/8)*8;

  logic [CB-1:0]         wlen_r, wlen_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_user_r, out_user_nxt;

  logic                  cfg_wr;
  logic                  cfg_hit;
  logic                  in_accept;
  logic                  out_free;
  logic                  out_load;
  logic                  idle;
  logic                  done;
  logic [CB-1:0]         divisor;
  wmm_pkg::chan_ctl_t    ctl;

  logic [SB-1:0] soil_max, soil_min, soil_mean;
  logic [SB-1:0] light_max, light_min, light_mean;
  logic [SB-1:0] soil_max_q, soil_min_q, soil_mean_q;
  logic [SB-1:0] light_max_q, light_min_q, light_mean_q;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = cfg_paddr[wmm_pkg::CFG_ADDR_BITS-1:wmm_pkg::CFG_WORD_LSB]
                      == wmm_pkg::REG_WINDOW_LENGTH;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_hit ? wmm_pkg::CFG_DATA_BITS'(wlen_r) : '0;
  assign wlen_nxt   = (cfg_wr && cfg_hit) ? cfg_pwdata[CB-1:0] : wlen_r;

  assign in_tready = idle;
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  wmm_ctrl #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_accept),
    .active   (in_tuser),
    .wlen     (wlen_r),
    .out_free (out_free),
    .ctl      (ctl),
    .divisor  (divisor),
    .done     (done),
    .out_load (out_load),
    .idle     (idle)
  );

  wmm_chan #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_soil (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .sample   (in_tdata[SB-1:0]),
    .divisor  (divisor),
    .win_max  (soil_max),
    .win_min  (soil_min),
    .win_mean (soil_mean)
  );

  wmm_chan #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_light (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .sample   (in_tdata[2*SB-1:SB]),
    .divisor  (divisor),
    .win_max  (light_max),
    .win_min  (light_min),
    .win_mean (light_mean)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_DATA_W'({light_mean, light_min, light_max,
                                   soil_mean, soil_min, soil_max});
      out_user_nxt  = done;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r      <= wmm_pkg::WINDOW_LENGTH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      wlen_r      <= wlen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign soil_max_q   = out_data_r[SB-1:0];
  assign soil_min_q   = out_data_r[2*SB-1:SB];
  assign soil_mean_q  = out_data_r[3*SB-1:2*SB];
  assign light_max_q  = out_data_r[4*SB-1:3*SB];
  assign light_min_q  = out_data_r[5*SB-1:4*SB];
  assign light_mean_q = out_data_r[6*SB-1:5*SB];

  `WMM_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `WMM_ASSERT_HOLDS(a_soil_order, !out_valid_r || (soil_min_q <= soil_mean_q && soil_mean_q <= soil_max_q))
  `WMM_ASSERT_HOLDS(a_light_order, !out_valid_r || (light_min_q <= light_mean_q && light_mean_q <= light_max_q))
endmodule
`default_nettype wire

### tb/wmm_stats_checker.sv
`timescale 1ns / 100ps
// Stream monitor for the windowed statistics block: predicts every result beat and compares it.
module wmm_stats_checker #(
  parameter int SB = 12
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  input  wire logic                                in_tready,
  // from bit 0: soil, light
  input  wire logic [((2*SB+7)/8)*8-1:0]           in_tdata,
  // active
  input  wire logic                                in_tuser,
  input  wire logic                                out_tvalid,
  input  wire logic                                out_tready,
  // from bit 0: soil max, soil min, soil mean, light max, light min, light mean
  input  wire logic [((6*SB+7)/8)*8-1:0]           out_tdata,
  // window_done
  input  wire logic                                out_tuser,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [wmm_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  wire logic [wmm_pkg::CFG_DATA_BITS-1:0]   cfg_pwdata,
  input  wire logic                                cfg_pready,
  output int                                       outstanding,
  output int                                       mismatches
);
  localparam int CB       = wmm_pkg::COUNT_BITS;
  localparam int SUM_BITS = SB + CB;

  // packed so that soil_max lands in the lowest bits, done on top
  typedef struct packed {
    logic          done;
    logic [SB-1:0] light_mean;
    logic [SB-1:0] light_min;
    logic [SB-1:0] light_max;
    logic [SB-1:0] soil_mean;
    logic [SB-1:0] soil_min;
    logic [SB-1:0] soil_max;
  } window_stats_t;

  // index 0 is soil, 1 is light
  logic [SB-1:0]         run_hi   [2];
  logic [SB-1:0]         run_lo   [2];
  logic [SUM_BITS-1:0]   run_sum  [2];
  logic [SB-1:0]         held_hi  [2];
  logic [SB-1:0]         held_lo  [2];
  logic [SB-1:0]         held_mean[2];
  logic [CB-1:0]         win_count;
  logic [CB-1:0]         win_len;
  window_stats_t         stats_due_q[$];

  function automatic window_stats_t fold_sample(input logic act, input logic [SB-1:0] soil,
                                                input logic [SB-1:0] light);
    window_stats_t         r;
    logic [SB-1:0]         smp [2];
    logic [CB-1:0]         limit;
    smp[0] = soil;
    smp[1] = light;
    r = '0;
    if (act) begin
      limit = (win_len == '0) ? CB'(1) : win_len;
      if (win_count >= limit) begin
        for (int c = 0; c < 2; c++) begin
          held_hi[c]   = run_hi[c];
          held_lo[c]   = run_lo[c];
          // count may exceed win_len when the length was lowered mid-window
          held_mean[c] = SB'(run_sum[c] / win_count);
          run_hi[c]    = '0;
          run_lo[c]    = '1;
          run_sum[c]   = '0;
        end
        win_count = '0;
        r.done = 1'b1;
      end
      for (int c = 0; c < 2; c++) begin
        if (smp[c] > run_hi[c]) run_hi[c] = smp[c];
        if (smp[c] < run_lo[c]) run_lo[c] = smp[c];
        run_sum[c] = run_sum[c] + SUM_BITS'(smp[c]);
      end
      win_count = win_count + 1'b1;
    end
    r.soil_max   = held_hi[0];
    r.soil_min   = held_lo[0];
    r.soil_mean  = held_mean[0];
    r.light_max  = held_hi[1];
    r.light_min  = held_lo[1];
    r.light_mean = held_mean[1];
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [SB-1:0] want,
                               input logic [SB-1:0] seen);
    if (seen !== want) begin
      $error("%s expected %0d got %0d", field, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    window_stats_t want;
    window_stats_t seen;
    if (!rst_n) begin
      for (int c = 0; c < 2; c++) begin
        run_hi[c]    = '0;
        run_lo[c]    = '1;
        run_sum[c]   = '0;
        held_hi[c]   = '0;
        held_lo[c]   = '0;
        held_mean[c] = '0;
      end
      win_count = '0;
      win_len = wmm_pkg::WINDOW_LENGTH_RESET;
      stats_due_q.delete();
      mismatches = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen = {out_tuser, out_tdata[6*SB-1:0]};
        if (stats_due_q.size() == 0) begin
          $error("result beat with nothing expected: done %0b data %h", out_tuser, out_tdata);
          mismatches++;
        end else begin
          want = stats_due_q.pop_front();
          compare_field("window_done", SB'(want.done), SB'(seen.done));
          compare_field("soil_window_max", want.soil_max, seen.soil_max);
          compare_field("soil_window_min", want.soil_min, seen.soil_min);
          compare_field("soil_window_mean", want.soil_mean, seen.soil_mean);
          compare_field("light_window_max", want.light_max, seen.light_max);
          compare_field("light_window_min", want.light_min, seen.light_min);
          compare_field("light_window_mean", want.light_mean, seen.light_mean);
        end
      end
      if (in_tvalid && in_tready)
        stats_due_q.push_back(fold_sample(in_tuser, in_tdata[SB-1:0], in_tdata[2*SB-1:SB]));
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[wmm_pkg::CFG_ADDR_BITS-1:wmm_pkg::CFG_WORD_LSB] ==
          wmm_pkg::REG_WINDOW_LENGTH)
        win_len = cfg_pwdata[CB-1:0];
    end
    outstanding <= stats_due_q.size();
  end
endmodule

### tb/windowed_min_max_mean_two_channel_tb.sv
`timescale 1ns / 100ps
// Testbench top for the windowed statistics block: clock, reset, stimulus and verdict.
module windowed_min_max_mean_two_channel_tb;
  localparam int SB       = 12;
  localparam int CB       = wmm_pkg::COUNT_BITS;
  localparam int AW       = wmm_pkg::CFG_ADDR_BITS;
  localparam int DW       = wmm_pkg::CFG_DATA_BITS;
  localparam int IN_W     = ((2*SB+7)/8)*8;
  localparam int OUT_W    = ((6*SB+7)/8)*8;
  localparam int LIMIT    = 1_000_000;
  localparam int RANDOM_SAMPLES = 1300;
  localparam logic [AW-1:0] WINDOW_LENGTH_ADDR =
    {wmm_pkg::REG_WINDOW_LENGTH, {wmm_pkg::CFG_WORD_LSB{1'b0}}};

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_W-1:0]          in_tdata;   // from bit 0: soil, light
  logic                     in_tuser;   // active
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_W-1:0]         out_tdata;  // soil max/min/mean, then light max/min/mean
  logic                     out_tuser;  // window_done
  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [AW-1:0]            cfg_paddr;
  logic [DW-1:0]            cfg_pwdata;
  logic [DW-1:0]            cfg_prdata;
  logic                     cfg_pready;
  int                       outstanding;
  int                       mismatches;

  int burst_left = 0;
  int rx_left = 0;
  int rx_mode = 0;
  int cycles = 0;

  always #2 clk = ~clk;

  windowed_min_max_mean_two_channel #(.SAMPLE_BITS(SB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  wmm_stats_checker #(.SB(SB)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .outstanding(outstanding), .mismatches(mismatches)
  );

  // receiver: spans of always-ready, random, sparse and long-stall behavior
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= (rx_left[2:0] == 3'd0);
      default: out_tready <= (rx_left < 8);
    endcase
  end

  function automatic logic [SB-1:0] pick_code();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return SB'($urandom_range(0, 15));
      3: return SB'(4095 - $urandom_range(0, 15));
      default: return SB'($urandom);
    endcase
  endfunction

  // one input beat; gaps only open at burst boundaries
  task automatic send_sample(input logic act, input logic [SB-1:0] soil,
                             input logic [SB-1:0] light);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= IN_W'({light, soil});
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_window_length(input logic [DW-1:0] value);
    drain_results();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= WINDOW_LENGTH_ADDR;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("windowed_min_max_mean_two_channel verification failed");
    $finish;
  end

  initial begin
    int beats_sent;
    int phase;
    int span;
    int pick;
    logic act;
    logic [CB-1:0] len;
    beats_sent = 0;
    phase = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: nothing latched yet, then extremes at the shortest windows
    send_sample(1'b0, 12'hABC, 12'h123);
    send_sample(1'b1, 12'h000, 12'hFFF);
    set_window_length(32'd1);
    send_sample(1'b1, 12'hFFF, 12'h000);
    send_sample(1'b0, 12'h555, 12'hAAA);
    send_sample(1'b1, 12'h000, 12'h000);
    send_sample(1'b1, 12'hFFF, 12'hFFF);
    send_sample(1'b1, 12'hFFF, 12'hFFF);
    // zero length acts as one
    set_window_length(32'd0);
    send_sample(1'b1, 12'h001, 12'hFFE);
    send_sample(1'b1, 12'h800, 12'h7FF);
    send_sample(1'b1, 12'hFFF, 12'h000);
    // shrink below the current count: close divides by the real count
    set_window_length(32'd4);
    send_sample(1'b1, 12'hFFF, 12'h001);
    send_sample(1'b1, 12'hFFE, 12'h002);
    set_window_length(32'd2);
    send_sample(1'b0, 12'h000, 12'h000);
    send_sample(1'b1, 12'h003, 12'hFFF);
    send_sample(1'b1, 12'h7FF, 12'h800);
    send_sample(1'b1, 12'h000, 12'hFFF);

    while (beats_sent < RANDOM_SAMPLES) begin
      pick = $urandom_range(0, 11);
      if (phase == 0)
        len = 8'd255;
      else if (phase == 1)
        len = 8'd1;
      else if (pick == 0)
        len = CB'($urandom_range(200, 255));
      else if (pick < 4)
        len = CB'($urandom_range(9, 40));
      else
        len = CB'($urandom_range(0, 8));
      set_window_length({24'($urandom), len});
      span = (len > 40) ? 2 * len + $urandom_range(0, 20) : $urandom_range(20, 90);
      for (int i = 0; i < span && beats_sent < RANDOM_SAMPLES; i++) begin
        act = ($urandom_range(0, 6) != 0);
        beats_sent++;
        send_sample(act, pick_code(), pick_code());
        if ($urandom_range(0, 99) == 0) drain_results();
      end
      phase++;
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("windowed_min_max_mean_two_channel verification clean");
    end else begin
      $display("windowed_min_max_mean_two_channel verification failed");
    end
    $finish;
  end
endmodule
